[rtl/spq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   // Request kinds carried in req_tuser.
   localparam logic KIND_ENQ = 1'b0;
   localparam logic KIND_DEQ = 1'b1;

   // Result status carried in rsp_tuser.
   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic enq;
      logic deq;
   } ctrl_type;

endpackage

`default_nettype wire

[rtl/spq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
   parameter int KEY_BITS    = 8,
   parameter int HANDLE_BITS = 32
) (
   input  wire                         clock,
   input  spq_pkg::ctrl_type           ctrl,
   input  wire  [KEY_BITS-1:0]         new_key,
   input  wire  [HANDLE_BITS-1:0]      new_handle,
   input  wire                         occupied,
   input  wire                         left_take,
   input  wire  [KEY_BITS-1:0]         left_key,
   input  wire  [HANDLE_BITS-1:0]      left_handle,
   input  wire  [KEY_BITS-1:0]         right_key,
   input  wire  [HANDLE_BITS-1:0]      right_handle,
   output logic                        take,
   output logic [KEY_BITS-1:0]         key,
   output logic [HANDLE_BITS-1:0]      handle
);

   logic [KEY_BITS-1:0]    key_ff;
   logic [KEY_BITS-1:0]    key_in;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [HANDLE_BITS-1:0] handle_in;

   // An empty cell behaves as if it held an infinitely large key, so the
   // new entry lands right after the last entry with a key not above it.
   assign take = !occupied || (key_ff > new_key);

   always_comb begin
      key_in    = key_ff;
      handle_in = handle_ff;
      if (ctrl.enq && take) begin
         if (left_take) begin
            key_in    = left_key;
            handle_in = left_handle;
         end else begin
            key_in    = new_key;
            handle_in = new_handle;
         end
      end else if (ctrl.deq) begin
         key_in    = right_key;
         handle_in = right_handle;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      handle_ff <= handle_in;
   end

   assign key    = key_ff;
   assign handle = handle_ff;

endmodule

`default_nettype wire

[rtl/stable_priority_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// Result: registered; it appears in the cycle after its request transaction is accepted.
// Throughput: one transaction per cycle; every cell compares and shifts in the
// same cycle. A waiting result blocks new requests until it is taken, and a new
// request is accepted in the same cycle as the waiting result is taken.
// Reset: synchronous; clears the entry count and the output valid. Cell contents
// are not reset and are only read below the entry count.
module stable_priority_queue #(
   parameter int DEPTH       = 16,
   parameter int KEY_BITS    = 8,
   parameter int HANDLE_BITS = 32
) (
   input  wire  clock,
   input  wire  reset,
   input  wire  req_tvalid,
   output logic req_tready,
   // kind
   input  wire  [0:0] req_tuser,
   // key, handle
   input  wire  [((KEY_BITS+HANDLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  wire  rsp_tready,
   // status
   output logic [1:0] rsp_tuser,
   // out_key, out_handle, occupancy
   output logic [((KEY_BITS+HANDLE_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] rsp_tdata
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int RSP_W = ((KEY_BITS + HANDLE_BITS + CNT_W + 7) / 8) * 8;

   logic                   accept;
   logic                   req_kind;
   logic [KEY_BITS-1:0]    req_key;
   logic [HANDLE_BITS-1:0] req_handle;
   logic                   full;
   logic                   empty;
   spq_pkg::ctrl_type      ctrl;

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   spq_pkg::status_type    status_ff;
   spq_pkg::status_type    status_in;
   logic [KEY_BITS-1:0]    out_key_ff;
   logic [KEY_BITS-1:0]    out_key_in;
   logic [HANDLE_BITS-1:0] out_handle_ff;
   logic [HANDLE_BITS-1:0] out_handle_in;
   logic [CNT_W-1:0]       occupancy_ff;

   logic [DEPTH-1:0]       cell_occ;
   logic [DEPTH-1:0]       cell_take;
   logic [KEY_BITS-1:0]    cell_key    [DEPTH];
   logic [HANDLE_BITS-1:0] cell_handle [DEPTH];

   assign req_kind   = req_tuser[0];
   assign req_key    = req_tdata[KEY_BITS-1:0];
   assign req_handle = req_tdata[KEY_BITS+HANDLE_BITS-1:KEY_BITS];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);

   assign ctrl.enq = accept && (req_kind == spq_pkg::KIND_ENQ) && !full;
   assign ctrl.deq = accept && (req_kind == spq_pkg::KIND_DEQ) && !empty;

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
         logic                   l_take;
         logic [KEY_BITS-1:0]    l_key;
         logic [HANDLE_BITS-1:0] l_handle;
         logic [KEY_BITS-1:0]    r_key;
         logic [HANDLE_BITS-1:0] r_handle;

         assign cell_occ[i] = (IDX < count_ff);

         if (i == 0) begin : g_head
            assign l_take   = 1'b0;
            assign l_key    = cell_key[i];
            assign l_handle = cell_handle[i];
         end else begin : g_body
            assign l_take   = cell_take[i-1];
            assign l_key    = cell_key[i-1];
            assign l_handle = cell_handle[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign r_key    = cell_key[i];
            assign r_handle = cell_handle[i];
         end else begin : g_inner
            assign r_key    = cell_key[i+1];
            assign r_handle = cell_handle[i+1];
         end

         spq_cell #(
            .KEY_BITS    (KEY_BITS),
            .HANDLE_BITS (HANDLE_BITS)
         ) u_cell (
            .clock        (clock),
            .ctrl         (ctrl),
            .new_key      (req_key),
            .new_handle   (req_handle),
            .occupied     (cell_occ[i]),
            .left_take    (l_take),
            .left_key     (l_key),
            .left_handle  (l_handle),
            .right_key    (r_key),
            .right_handle (r_handle),
            .take         (cell_take[i]),
            .key          (cell_key[i]),
            .handle       (cell_handle[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctrl.enq) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.deq) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      out_key_in    = '0;
      out_handle_in = '0;
      if (req_kind == spq_pkg::KIND_ENQ) begin
         status_in = full ? spq_pkg::ST_FULL : spq_pkg::ST_ENQUEUED;
      end else if (empty) begin
         status_in = spq_pkg::ST_EMPTY;
      end else begin
         status_in     = spq_pkg::ST_DEQUEUED;
         out_key_in    = cell_key[0];
         out_handle_in = cell_handle[0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status_in;
         out_key_ff    <= out_key_in;
         out_handle_ff <= out_handle_in;
         occupancy_ff  <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = RSP_W'({occupancy_ff, out_handle_ff, out_key_ff});

   // Stored entries must stay in ascending key order.
   logic [DEPTH-2:0] order_ok;
   generate
      for (genvar j = 0; j < DEPTH - 1; j++) begin : g_order
         assign order_ok[j] = !cell_occ[j+1] || (cell_key[j] <= cell_key[j+1]);
      end
   endgenerate

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_sorted : assert property (@(posedge clock) disable iff (reset)
      &order_ok)
      else $error("stored keys out of order");

   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

   a_empty_deq : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == spq_pkg::KIND_DEQ) && empty)
      |=> (status_ff == spq_pkg::ST_EMPTY) && (count_ff == '0))
      else $error("dequeue from empty queue mishandled");

endmodule

`default_nettype wire

[tb/sv/stable_priority_queue_tb.sv]
`timescale 1ns / 1ps

module stable_priority_queue_tb;

   localparam int DEPTH       = 16;
   localparam int KEY_BITS    = 8;
   localparam int HANDLE_BITS = 32;
   localparam int OCC_BITS    = $clog2(DEPTH + 1);
   localparam int REQ_BITS    = ((KEY_BITS + HANDLE_BITS + 7) / 8) * 8;
   localparam int RSP_FIELDS  = KEY_BITS + HANDLE_BITS + OCC_BITS;
   localparam int RSP_BITS    = ((RSP_FIELDS + 7) / 8) * 8;
   localparam int STALL_LIMIT = 2000;

   typedef struct {
      spq_pkg::status_type     status;
      logic [KEY_BITS-1:0]     key;
      logic [HANDLE_BITS-1:0]  handle;
      logic [OCC_BITS-1:0]     occupancy;
   } outcome_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [0:0]          req_tuser  = spq_pkg::KIND_ENQ;   // kind
   logic [REQ_BITS-1:0] req_tdata  = '0;                  // key, handle
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [1:0]          rsp_tuser;               // status
   logic [RSP_BITS-1:0] rsp_tdata;               // out_key, out_handle, occupancy

   // Shadow copy of the sorted queue contents.
   logic [KEY_BITS-1:0]    held_keys[DEPTH];
   logic [HANDLE_BITS-1:0] held_handles[DEPTH];
   int                     held_count = 0;

   outcome_type queue_outcomes[$];
   int       mismatches  = 0;
   int       idle_cycles = 0;
   int       req_gap_max   = 13;
   int       rsp_pause_max = 13;

   stable_priority_queue #(
      .DEPTH      (DEPTH),
      .KEY_BITS   (KEY_BITS),
      .HANDLE_BITS(HANDLE_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one operation to the shadow queue and returns the response it should give.
   function automatic outcome_type apply_queue_op(logic kind, logic [KEY_BITS-1:0] key,
                                                  logic [HANDLE_BITS-1:0] handle);
      outcome_type r;
      int          pos;
      r.status = spq_pkg::ST_ENQUEUED;
      r.key    = '0;
      r.handle = '0;
      if (kind == spq_pkg::KIND_ENQ) begin
         if (held_count >= DEPTH) begin
            r.status = spq_pkg::ST_FULL;
         end else begin
            // Equal keys go behind the ones already stored, so ties leave in arrival order.
            pos = 0;
            while (pos < held_count && held_keys[pos] <= key)
               pos++;
            for (int i = held_count; i > pos; i--) begin
               held_keys[i]    = held_keys[i-1];
               held_handles[i] = held_handles[i-1];
            end
            held_keys[pos]    = key;
            held_handles[pos] = handle;
            held_count++;
         end
      end else if (held_count == 0) begin
         r.status = spq_pkg::ST_EMPTY;
      end else begin
         r.status = spq_pkg::ST_DEQUEUED;
         r.key    = held_keys[0];
         r.handle = held_handles[0];
         for (int i = 1; i < held_count; i++) begin
            held_keys[i-1]    = held_keys[i];
            held_handles[i-1] = held_handles[i];
         end
         held_count--;
      end
      r.occupancy = held_count[OCC_BITS-1:0];
      return r;
   endfunction

   // Presents one request and holds it until the transaction completes.
   task automatic issue_op(logic kind, logic [KEY_BITS-1:0] key,
                           logic [HANDLE_BITS-1:0] handle);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {handle, key};
      do
         @(posedge clock);
      while (req_tready !== 1'b1);
      queue_outcomes.push_back(apply_queue_op(kind, key, handle));
   endtask

   task automatic test_empty_dequeue();
      issue_op(spq_pkg::KIND_DEQ, 8'hFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_order_and_ties();
      issue_op(spq_pkg::KIND_ENQ, 8'hFF, 32'hFFFF_FFFF);
      issue_op(spq_pkg::KIND_ENQ, 8'h00, 32'h0000_0000);
      issue_op(spq_pkg::KIND_ENQ, 8'h00, 32'h0000_0001);
      issue_op(spq_pkg::KIND_ENQ, 8'hFF, 32'h0000_0002);
      repeat (4) issue_op(spq_pkg::KIND_DEQ, 8'h00, 32'h0000_0000);
   endtask

   // Fills the queue and pushes past the top; the leftover entries drain in the random part.
   task automatic test_overflow();
      repeat (DEPTH) issue_op(spq_pkg::KIND_ENQ, KEY_BITS'($urandom_range(0, 255)),
                              HANDLE_BITS'($urandom()));
      issue_op(spq_pkg::KIND_ENQ, 8'h00, 32'hFFFF_FFFF);
      issue_op(spq_pkg::KIND_ENQ, 8'hFF, 32'h0000_0000);
   endtask

   task automatic test_random_traffic();
      int   enq_pct;
      bit   narrow_keys;
      logic kind;
      for (int seg = 0; seg < 19; seg++) begin
         case ($urandom_range(0, 2))
            0: enq_pct = 30;
            1: enq_pct = 50;
            default: enq_pct = 70;
         endcase
         narrow_keys   = 1'($urandom_range(0, 1));
         req_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 13;
         rsp_pause_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
         for (int n = 0; n < 50; n++) begin
            kind = ($urandom_range(1, 100) <= enq_pct) ? spq_pkg::KIND_ENQ
                                                        : spq_pkg::KIND_DEQ;
            issue_op(kind, narrow_keys ? KEY_BITS'($urandom_range(0, 3))
                                       : KEY_BITS'($urandom_range(0, 255)),
                     HANDLE_BITS'($urandom()));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_dequeue();
      test_order_and_ties();
      test_overflow();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (queue_outcomes.size() > 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Response side: a random pause before each response is taken.
   initial begin : rsp_sink
      int pause;
      while (reset)
         @(posedge clock);
      forever begin
         pause = $urandom_range(0, rsp_pause_max);
         if (pause > 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do
            @(posedge clock);
         while (rsp_tvalid !== 1'b1);
      end
   end

   always @(posedge clock) begin : rsp_check
      outcome_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (queue_outcomes.size() == 0) begin
            $display("%0t: response with none pending: status %0d tdata %h",
                     $time, rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = queue_outcomes.pop_front();
            if (rsp_tuser !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[KEY_BITS-1:0] !== want.key) begin
               $display("%0t: out_key expected %h actual %h",
                        $time, want.key, rsp_tdata[KEY_BITS-1:0]);
               mismatches++;
            end
            if (rsp_tdata[KEY_BITS+HANDLE_BITS-1:KEY_BITS] !== want.handle) begin
               $display("%0t: out_handle expected %h actual %h",
                        $time, want.handle, rsp_tdata[KEY_BITS+HANDLE_BITS-1:KEY_BITS]);
               mismatches++;
            end
            if (rsp_tdata[RSP_FIELDS-1:KEY_BITS+HANDLE_BITS] !== want.occupancy) begin
               $display("%0t: occupancy expected %0d actual %0d",
                        $time, want.occupancy, rsp_tdata[RSP_FIELDS-1:KEY_BITS+HANDLE_BITS]);
               mismatches++;
            end
            if (rsp_tdata[RSP_BITS-1:RSP_FIELDS] !== '0) begin
               $display("%0t: tdata padding expected 0 actual %h",
                        $time, rsp_tdata[RSP_BITS-1:RSP_FIELDS]);
               mismatches++;
            end
         end
      end
   end

   // A cycle with neither transaction counts toward the hang limit.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
